@@ hdl/beam_best_k_keeper_top_defines.svh @@
// ----------------------------------------------------------------------------
// beam_best_k_keeper_top_defines
// Assertion macros shared by the checker of the beam best-k keeper.
// ----------------------------------------------------------------------------
`ifndef BEAM_BEST_K_KEEPER_TOP_DEFINES_SVH
`define BEAM_BEST_K_KEEPER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is held
`define BKK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held
`define BKK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bkk_pkg.sv @@
// ----------------------------------------------------------------------------
// bkk_pkg
// Types and constants of the beam best-k keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package bkk_pkg;

    localparam int MAX_KEEP = 8;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int SCORE_W  = 26;
    localparam int UTIL_W   = 17;
    localparam int ID_W     = 16;
    localparam int SLOT_W   = 3;
    localparam int KEEP_W   = 4;
    localparam int CFG_W    = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MARGIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UTIL_TOLERANCE = 2'd2;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_DUMP    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [UTIL_W-1:0]  util;
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    pieces;
    } t_entry;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic at_end;     // cell index >= count-1: insertion search stops here
        logic is_last;    // cell holds the current last entry
        logic insert;     // apply an accepted insertion this cycle
        logic shift_out;  // dump: take the right-hand neighbour's entry
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hdl/beam_best_k_keeper_top.sv @@
// ----------------------------------------------------------------------------
// beam_best_k_keeper_top
// Ordered list of the best candidates of one beam-search level.
// Input channel i_in_valid/o_in_ready carries one candidate per transfer;
// output channel o_out_valid/i_out_ready carries result items. Each
// candidate gives one verdict; with level_end set the verdict is followed
// by one dump item per kept entry, position 0 upward, and the list clears.
// A candidate is taken in the idle state, enters evaluation in the next cycle
// and, once the output register is free, has its verdict registered there.
// It is ranked in the single compare-and-shift step of the cell chain; no
// new candidate is taken until its verdict and dump items are registered.
// A waiting output does not block the next transfer in; evaluation and dump
// steps hold while the receiver stalls. Reset clears the count and loads
// keep count 3, margin 0 and tolerance 0. Configuration writes on i_cfg_we
// take effect at once and are to be made while idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module beam_best_k_keeper_top import bkk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // candidate channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [SCORE_W-1:0]   i_node_score,
    input  logic [UTIL_W-1:0]    i_bin_util,
    input  logic [ID_W-1:0]      i_node_id,
    input  logic [ID_W-1:0]      i_pieces_left,
    input  logic                 i_level_end,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_result_kind,
    output logic                 o_accepted,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [ID_W-1:0]      o_kept_id,
    output logic [ID_W-1:0]      o_kept_pieces,
    output logic                 o_last
);

    localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    // Configuration registers
    logic [KEEP_W-1:0]  r_keep;
    logic [SCORE_W-1:0] r_margin;
    logic [UTIL_W-1:0]  r_tol;

    // Sequencer
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_idx, n_idx;
    t_entry             r_cand;
    logic               r_dump;

    // Output register
    logic               r_out_valid;
    logic               r_kind;
    logic               r_acc;
    logic [SLOT_W-1:0]  r_slot;
    logic [ID_W-1:0]    r_kid;
    logic [ID_W-1:0]    r_kpieces;
    logic               r_last;

    logic               in_fire;
    logic               out_free;
    logic               eval_go;
    logic               dump_go;
    logic               dump_last;
    logic               acc;
    logic [CNT_W-1:0]   keep_eff;
    logic [CNT_W-1:0]   new_cnt;
    logic [IDX_W-1:0]   pos;
    logic [SCORE_W:0]   cand_sm;

    t_cell_ctl          cell_ctl [MAX_KEEP];
    t_entry             cell_q   [MAX_KEEP];
    logic [MAX_KEEP:0]  found;
    logic [MAX_KEEP-1:0] ins;
    logic [MAX_KEEP-1:0] ok;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep   <= KEEP_W'(3);
            r_margin <= '0;
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEEP_COUNT:     r_keep   <= i_cfg_wdata[KEEP_W-1:0];
                CFG_SCORE_MARGIN:   r_margin <= i_cfg_wdata[SCORE_W-1:0];
                CFG_UTIL_TOLERANCE: r_tol    <= i_cfg_wdata[UTIL_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the keep count to 1..MAX_KEEP
    always_comb begin
        if (r_keep == '0) begin
            keep_eff = CNT_W'(1);
        end else if (int'(r_keep) > MAX_KEEP) begin
            keep_eff = CNT_W'(MAX_KEEP);
        end else begin
            keep_eff = CNT_W'(r_keep);
        end
    end

    // ---- handshake strobes ----
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        in_fire    = i_in_valid && o_in_ready;
        out_free   = !r_out_valid || i_out_ready;
        eval_go    = (r_state == ST_EVAL) && out_free;
        dump_go    = (r_state == ST_DUMP) && out_free;
        dump_last  = (r_idx + CNT_W'(1)) == r_cnt;
    end

    // ---- cell chain ----
    assign cand_sm  = {1'b0, r_cand.score} + {1'b0, r_margin};
    assign found[0] = 1'b0;

    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;

        always_comb begin
            cell_ctl[g].at_end    = (CNT_W'(g) + CNT_W'(1)) >= r_cnt;
            cell_ctl[g].is_last   = (CNT_W'(g) + CNT_W'(1)) == r_cnt;
            cell_ctl[g].insert    = eval_go && acc;
            cell_ctl[g].shift_out = dump_go;
        end

        if (g == 0) begin : g_first
            assign left_e = r_cand;
        end else begin : g_mid
            assign left_e = cell_q[g-1];
        end

        if (g == MAX_KEEP - 1) begin : g_tail
            assign right_e = r_cand;
        end else begin : g_body
            assign right_e = cell_q[g+1];
        end

        bkk_cell u_cell (
            .i_clk     (i_clk),
            .i_cand    (r_cand),
            .i_cand_sm (cand_sm),
            .i_margin  (r_margin),
            .i_tol     (r_tol),
            .i_left    (left_e),
            .i_right   (right_e),
            .i_ctl     (cell_ctl[g]),
            .i_found   (found[g]),
            .o_found   (found[g+1]),
            .o_ins     (ins[g]),
            .o_ok      (ok[g]),
            .o_entry   (cell_q[g])
        );
    end

    // Verdict: empty list, room left, or the last entry beaten
    always_comb begin
        acc     = (r_cnt == '0) || (r_cnt < keep_eff) || (|ok);
        new_cnt = (r_cnt < keep_eff) ? r_cnt + CNT_W'(1) : r_cnt;
        pos     = '0;
        for (int i = 0; i < MAX_KEEP; i++) begin
            if (ins[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    // ---- state machine ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (out_free) n_state = r_dump ? ST_DUMP : ST_IDLE;
            end
            ST_DUMP: begin
                if (out_free && dump_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (eval_go) begin
            n_idx = '0;
            if (acc) n_cnt = new_cnt;
        end else if (dump_go) begin
            n_idx = r_idx + CNT_W'(1);
            if (dump_last) n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            if (eval_go || dump_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the candidate for its evaluation step
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cand.score  <= i_node_score;
            r_cand.util   <= i_bin_util;
            r_cand.id     <= i_node_id;
            r_cand.pieces <= i_pieces_left;
            r_dump        <= i_level_end;
        end
    end

    // Result payload: verdict from the chain, dump item from cell 0
    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_kind    <= KIND_VERDICT;
            r_acc     <= acc;
            r_slot    <= acc ? SLOT_W'(pos) : '0;
            r_kid     <= '0;
            r_kpieces <= '0;
            r_last    <= !r_dump;
        end else if (dump_go) begin
            r_kind    <= KIND_DUMP;
            r_acc     <= 1'b0;
            r_slot    <= SLOT_W'(r_idx);
            r_kid     <= cell_q[0].id;
            r_kpieces <= cell_q[0].pieces;
            r_last    <= dump_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_accepted    = r_acc;
    assign o_slot        = r_slot;
    assign o_kept_id     = r_kid;
    assign o_kept_pieces = r_kpieces;
    assign o_last        = r_last;

endmodule

`default_nettype wire

@@ hdl/bkk_cell.sv @@
// ----------------------------------------------------------------------------
// bkk_cell
// One list position: holds an entry, compares it with the candidate and
// takes part in the insertion and dump shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module bkk_cell import bkk_pkg::*; (
    input  logic               i_clk,
    input  t_entry             i_cand,
    input  logic [SCORE_W:0]   i_cand_sm,
    input  logic [SCORE_W-1:0] i_margin,
    input  logic [UTIL_W-1:0]  i_tol,
    input  t_entry             i_left,
    input  t_entry             i_right,
    input  t_cell_ctl          i_ctl,
    input  logic               i_found,
    output logic               o_found,
    output logic               o_ins,
    output logic               o_ok,
    output t_entry             o_entry
);

    t_entry           r_e;
    logic             lt;
    logic             stop;
    logic             beat;
    logic             near;
    logic [SCORE_W:0] last_sm;
    logic [UTIL_W:0]  last_ut;

    always_comb begin
        lt      = i_cand_sm < {1'b0, r_e.score};
        last_sm = {1'b0, r_e.score} + {1'b0, i_margin};
        last_ut = {1'b0, r_e.util} + {1'b0, i_tol};
        beat    = i_cand_sm <= {1'b0, r_e.score};
        near    = ({1'b0, i_cand.score} <= last_sm) && ({1'b0, i_cand.util} > last_ut);
        stop    = lt || i_ctl.at_end;
        o_ins   = !i_found && stop;
        o_found = i_found || stop;
        o_ok    = i_ctl.is_last && (beat || near);
        o_entry = r_e;
    end

    // Insert here, make room from the left, or in a dump take from the right
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            if (o_ins) begin
                r_e <= i_cand;
            end else if (i_found) begin
                r_e <= i_left;
            end
        end else if (i_ctl.shift_out) begin
            r_e <= i_right;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bkk_checker.sv @@
// ----------------------------------------------------------------------------
// bkk_checker
// Port-level checks of the beam best-k keeper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "beam_best_k_keeper_top_defines.svh"

module bkk_checker import bkk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 o_result_kind,
    input  logic                 o_accepted,
    input  logic [SLOT_W-1:0]    o_slot,
    input  logic [ID_W-1:0]      o_kept_id,
    input  logic [ID_W-1:0]      o_kept_pieces,
    input  logic                 o_last
);

    logic                       in_xfer;
    logic                       out_stall;
    logic                       verdict_rej;
    logic                       dump_item;
    logic [SLOT_W+2*ID_W+2:0]   out_word;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_word    = {o_result_kind, o_accepted, o_slot, o_kept_id, o_kept_pieces, o_last};
    assign verdict_rej = o_out_valid && (o_result_kind == KIND_VERDICT) && !o_accepted;
    assign dump_item   = o_out_valid && (o_result_kind == KIND_DUMP);

    // Stalled result holds
    `BKK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word), "stalled result changed")
    // A candidate transfer is evaluated before the next one is taken
    `BKK_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_xfer, !o_in_ready, "back-to-back take")
    // Rejected candidate reports slot zero
    `BKK_ASSERT_NOW(a_reject_slot, i_clk, i_rst_n, verdict_rej, o_slot == '0, "reject slot")
    // Dump items never flag acceptance
    `BKK_ASSERT_NOW(a_dump_acc, i_clk, i_rst_n, dump_item, !o_accepted, "dump flagged accepted")

endmodule

bind beam_best_k_keeper_top bkk_checker u_bkk_checker (.*);

`default_nettype wire

@@ tb/bkk_list_checker.sv @@
// ----------------------------------------------------------------------------
// bkk_list_checker
// Watches both channels and the register port of the beam best-k keeper,
// keeps its own copy of the ranked list, predicts every result item and
// compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
module bkk_list_checker import bkk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [SCORE_W-1:0]   i_node_score,
    input  logic [UTIL_W-1:0]    i_bin_util,
    input  logic [ID_W-1:0]      i_node_id,
    input  logic [ID_W-1:0]      i_pieces_left,
    input  logic                 i_level_end,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_result_kind,
    input  logic                 i_accepted,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [ID_W-1:0]      i_kept_id,
    input  logic [ID_W-1:0]      i_kept_pieces,
    input  logic                 i_last,
    output int unsigned          o_mismatches,
    output int unsigned          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   pieces;
        logic              last;
    } t_result;

    // register copies
    logic [KEEP_W-1:0]  keep_reg;
    logic [SCORE_W-1:0] margin_reg;
    logic [UTIL_W-1:0]  tol_reg;

    // ranked list, best first
    logic [SCORE_W-1:0] held_score  [MAX_KEEP];
    logic [UTIL_W-1:0]  held_util   [MAX_KEEP];
    logic [ID_W-1:0]    held_id     [MAX_KEEP];
    logic [ID_W-1:0]    held_pieces [MAX_KEEP];
    int                 held_len;

    t_result     due_results [$];
    int unsigned mismatch_total = 0;
    int unsigned results_checked = 0;

    assign o_mismatches = mismatch_total;

    task automatic flag_mismatch(input string what);
        if (mismatch_total < 40)
            $display("[%0t] mismatch on result %0d: %s", $time, results_checked, what);
        mismatch_total++;
    endtask

    task automatic compare_field(input string name, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Rank one candidate against the list, update it and queue the verdict
    // followed, on a level end, by the dump of every kept entry.
    task automatic rank_candidate(input logic [SCORE_W-1:0] score,
                                  input logic [UTIL_W-1:0] util,
                                  input logic [ID_W-1:0] id,
                                  input logic [ID_W-1:0] pieces,
                                  input logic closes_level);
        int               eff_keep;
        int               cnt;
        int               pos;
        int               grown;
        int               i;
        logic             admit;
        logic [SCORE_W:0] score_hi;
        logic [SCORE_W:0] last_hi;
        logic [UTIL_W:0]  util_bar;
        t_result          r;

        if (keep_reg == '0)
            eff_keep = 1;
        else if (int'(keep_reg) > MAX_KEEP)
            eff_keep = MAX_KEEP;
        else
            eff_keep = int'(keep_reg);

        cnt      = held_len;
        pos      = 0;
        score_hi = {1'b0, score} + {1'b0, margin_reg};
        admit    = (cnt == 0);
        if (cnt != 0) begin
            last_hi  = {1'b0, held_score[cnt-1]} + {1'b0, margin_reg};
            util_bar = {1'b0, held_util[cnt-1]} + {1'b0, tol_reg};
            if (cnt < eff_keep)
                admit = 1'b1;
            if (score_hi <= {1'b0, held_score[cnt-1]})
                admit = 1'b1;
            else if ({1'b0, score} <= last_hi && {1'b0, util} > util_bar)
                admit = 1'b1;
        end

        if (admit) begin
            // search stops at the current last position at the latest
            if (cnt > 0)
                while (pos < cnt - 1 && score_hi >= {1'b0, held_score[pos]})
                    pos++;
            grown = (cnt < eff_keep) ? cnt + 1 : cnt;
            for (i = grown - 1; i > pos; i--) begin
                held_score[i]  = held_score[i-1];
                held_util[i]   = held_util[i-1];
                held_id[i]     = held_id[i-1];
                held_pieces[i] = held_pieces[i-1];
            end
            held_score[pos]  = score;
            held_util[pos]   = util;
            held_id[pos]     = id;
            held_pieces[pos] = pieces;
            cnt = grown;
        end
        held_len = cnt;

        r.kind     = KIND_VERDICT;
        r.accepted = admit;
        r.slot     = admit ? SLOT_W'(pos) : '0;
        r.id       = '0;
        r.pieces   = '0;
        r.last     = !(closes_level && cnt > 0);
        due_results = {due_results, r};

        if (closes_level) begin
            for (i = 0; i < cnt; i++) begin
                r.kind     = KIND_DUMP;
                r.accepted = 1'b0;
                r.slot     = SLOT_W'(i);
                r.id       = held_id[i];
                r.pieces   = held_pieces[i];
                r.last     = (i + 1 == cnt);
                due_results = {due_results, r};
            end
            held_len = 0;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (due_results.size() == 0) begin
            flag_mismatch($sformatf("unpredicted result, kind %0d id %0h",
                                    i_result_kind, i_kept_id));
        end else begin
            want = due_results.pop_front();
            compare_field("result_kind", ID_W'(i_result_kind), ID_W'(want.kind));
            compare_field("accepted", ID_W'(i_accepted), ID_W'(want.accepted));
            compare_field("slot", ID_W'(i_slot), ID_W'(want.slot));
            compare_field("kept_id", i_kept_id, want.id);
            compare_field("kept_pieces", i_kept_pieces, want.pieces);
            compare_field("last", ID_W'(i_last), ID_W'(want.last));
        end
        results_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_results.delete();
            keep_reg   = KEEP_W'(3);
            margin_reg = '0;
            tol_reg    = '0;
            held_len   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEEP_COUNT:     keep_reg   = i_cfg_wdata[KEEP_W-1:0];
                    CFG_SCORE_MARGIN:   margin_reg = i_cfg_wdata[SCORE_W-1:0];
                    CFG_UTIL_TOLERANCE: tol_reg    = i_cfg_wdata[UTIL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                rank_candidate(i_node_score, i_bin_util, i_node_id, i_pieces_left,
                               i_level_end);
            if (i_out_valid && i_out_ready)
                check_result();
        end
        o_outstanding <= due_results.size();
    end

endmodule

@@ tb/tb_beam_best_k_keeper_top.sv @@
// ----------------------------------------------------------------------------
// tb_beam_best_k_keeper_top
// Drives candidates into the beam best-k keeper and judges the run. A
// directed opening walks the acceptance rules, the capped insertion search,
// the tie-break and the dump; random levels then follow under a series of
// register settings, with bursty input and a patterned output stall. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_beam_best_k_keeper_top import bkk_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 156;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SCORE_LIMIT  = (1 << SCORE_W) - 1;
    localparam int UTIL_LIMIT   = 65536;

    localparam logic [SCORE_W-1:0]   SCORE_TOP = '1;
    localparam logic [UTIL_W-1:0]    UTIL_FULL = UTIL_W'(UTIL_LIMIT);
    // index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // shape of the scores within one random level
    typedef enum logic [1:0] {
        SPREAD_TIGHT,
        SPREAD_NEAR,
        SPREAD_WIDE,
        SPREAD_EDGE
    } t_spread;

    // output stall styles
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKS
    } t_rx_mode;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [SCORE_W-1:0] node_score;
    logic [UTIL_W-1:0]  bin_util;
    logic [ID_W-1:0]    node_id;
    logic [ID_W-1:0]    pieces_left;
    logic               level_end;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               result_kind;
    logic               accepted;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    kept_id;
    logic [ID_W-1:0]    kept_pieces;
    logic               last;

    int unsigned mismatches;
    int unsigned outstanding;

    int burst_left       = 0;
    int candidates_sent  = 0;
    int levels_closed    = 0;
    int settings_used    = 0;
    int directed_count   = 0;
    int results_seen     = 0;
    int quiet_cycles     = 0;

    t_rx_mode   rx_mode = RX_STEADY;
    logic [7:0] rx_tick = '0;

    beam_best_k_keeper_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_node_score  (node_score),
        .i_bin_util    (bin_util),
        .i_node_id     (node_id),
        .i_pieces_left (pieces_left),
        .i_level_end   (level_end),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_result_kind (result_kind),
        .o_accepted    (accepted),
        .o_slot        (slot),
        .o_kept_id     (kept_id),
        .o_kept_pieces (kept_pieces),
        .o_last        (last)
    );

    bkk_list_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_node_score  (node_score),
        .i_bin_util    (bin_util),
        .i_node_id     (node_id),
        .i_pieces_left (pieces_left),
        .i_level_end   (level_end),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_result_kind (result_kind),
        .i_accepted    (accepted),
        .i_slot        (slot),
        .i_kept_id     (kept_id),
        .i_kept_pieces (kept_pieces),
        .i_last        (last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: change stall style whenever the tick counter wraps. Steady and
    // coin-flip phases give full-rate and ragged draining, the sparse style
    // takes one result in four, and the block style holds ready low while
    // tick bits 4:3 are zero, so that dumps back up behind a stalled output.
    always @(posedge clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == '1)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_STEADY: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
            default:   out_ready <= (rx_tick[4:3] != 2'd0);
        endcase
    end

    // Watchdog: any transfer on either channel restarts the count; a long
    // quiet stretch means the block has hung.
    always @(posedge clk) begin
        if (out_valid && out_ready)
            results_seen <= results_seen + 1;
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_beam_best_k_keeper_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one candidate and hold it until the transfer. The sender works
    // in bursts: when a burst runs out, drop valid for a random gap first.
    task automatic send_candidate(input logic [SCORE_W-1:0] score,
                                  input logic [UTIL_W-1:0] util,
                                  input logic [ID_W-1:0] id,
                                  input logic [ID_W-1:0] pieces,
                                  input logic closes_level);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                : $urandom_range(1, 5))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid    <= 1'b1;
        node_score  <= score;
        bin_util    <= util;
        node_id     <= id;
        pieces_left <= pieces;
        level_end   <= closes_level;
        do @(posedge clk); while (!in_ready);
        candidates_sent++;
        if (closes_level)
            levels_closed++;
    endtask

    // Hold the input until every predicted result has left the block, then
    // give it time to return to idle.
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Write all three registers while idle. Unused upper data bits carry
    // noise, which the block must drop.
    task automatic program_regs(input logic [KEEP_W-1:0] keep,
                                input logic [SCORE_W-1:0] margin,
                                input logic [UTIL_W-1:0] tol,
                                input logic poke_spare);
        logic [CFG_W-1:0] word;
        settle();
        word = CFG_W'($urandom);
        word[KEEP_W-1:0] = keep;
        write_reg(CFG_KEEP_COUNT, word);
        write_reg(CFG_SCORE_MARGIN, CFG_W'(margin));
        word = CFG_W'($urandom);
        word[UTIL_W-1:0] = tol;
        write_reg(CFG_UTIL_TOLERANCE, word);
        if (poke_spare)
            write_reg(CFG_SPARE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int                 phase;
        int                 phase_end;
        int                 level_len;
        int                 j;
        logic [KEEP_W-1:0]  keep;
        logic [SCORE_W-1:0] margin;
        logic [UTIL_W-1:0]  tol;
        logic [SCORE_W-1:0] base;
        logic [SCORE_W-1:0] score;
        logic [UTIL_W-1:0]  util;
        logic [UTIL_W-1:0]  util_base;
        t_spread            spread;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_idx     <= CFG_KEEP_COUNT;
        cfg_wdata   <= '0;
        in_valid    <= 1'b0;
        node_score  <= '0;
        bin_util    <= '0;
        node_id     <= '0;
        pieces_left <= '0;
        level_end   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: keep 3, no margin, no tolerance.
        // Empty list takes the worst possible candidate, then dumps it.
        send_candidate(SCORE_TOP, UTIL_FULL, 16'hFFFF, 16'hFFFF, 1'b1);
        send_candidate(26'd100, 17'h08000, 16'd1, 16'd10, 1'b0);
        send_candidate(26'd50,  17'h08000, 16'd2, 16'd20, 1'b0);
        // worse than all, yet the search stops one short of the end
        send_candidate(26'd200, 17'h04000, 16'd3, 16'd30, 1'b0);
        // full list, worse than the last: rejected
        send_candidate(26'd300, 17'h0FFFF, 16'd4, 16'd40, 1'b0);
        // beats the last: goes to the front and pushes the last out
        send_candidate(26'd10,  17'h00000, 16'd5, 16'd50, 1'b0);
        // equal score, utilisation just above the last: wins on the equal score
        send_candidate(26'd200, 17'h04001, 16'd6, 16'd60, 1'b0);
        // equal score and utilisation: accepted, equal score beats the last
        send_candidate(26'd200, 17'h04001, 16'd7, 16'd70, 1'b0);
        send_candidate(26'd0,   17'h00000, 16'd0, 16'd0,  1'b1);

        // Keep one, widest margin and tolerance: only the first gets in,
        // and the margin sums overflow the score width.
        program_regs(KEEP_W'(1), SCORE_TOP, UTIL_FULL, 1'b0);
        send_candidate(26'd0,     17'h00000, 16'hA5A5, 16'h5A5A, 1'b0);
        send_candidate(26'd0,     UTIL_FULL, 16'h0001, 16'h0002, 1'b0);
        send_candidate(SCORE_TOP, UTIL_FULL, 16'h8000, 16'h8000, 1'b1);

        // Keep eight, small margin and tolerance: overfill and dump a full
        // list. Also poke the unused register index.
        program_regs(KEEP_W'(8), 26'd16, 17'd100, 1'b1);
        send_candidate(26'd1000, 17'd500,  16'd11, 16'd1, 1'b0);
        send_candidate(26'd1010, 17'd700,  16'd12, 16'd2, 1'b0);
        send_candidate(26'd990,  17'd300,  16'd13, 16'd3, 1'b0);
        send_candidate(26'd1020, 17'd900,  16'd14, 16'd4, 1'b0);
        send_candidate(26'd1016, 17'd100,  16'd15, 16'd5, 1'b0);
        send_candidate(26'd5000, 17'd0,    16'd16, 16'd6, 1'b0);
        send_candidate(26'd980,  17'd1000, 16'd17, 16'd7, 1'b0);
        send_candidate(26'd1000, 17'd500,  16'd18, 16'd8, 1'b0);
        send_candidate(26'd2000, 17'd50,   16'd19, 16'd9, 1'b0);
        send_candidate(26'd10,   17'd50,   16'd20, 16'd10, 1'b0);
        send_candidate(26'd5016, 17'd101,  16'd21, 16'd11, 1'b0);
        send_candidate(26'd5016, 17'd400,  16'd22, 16'd12, 1'b1);
        directed_count = candidates_sent;

        // Random levels. The first settings are fixed at the extremes,
        // including keep counts below and above the usable range; later
        // ones are drawn. A phase may end mid-level, so entries carry over
        // into the next setting.
        phase = 0;
        while (candidates_sent < directed_count + RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    keep = KEEP_W'(8); margin = '0; tol = '0;
                end
                1: begin
                    keep = KEEP_W'(1); margin = SCORE_TOP; tol = UTIL_FULL;
                end
                2: begin
                    keep   = '0;
                    margin = SCORE_W'($urandom_range(0, 600));
                    tol    = UTIL_W'($urandom_range(0, 64));
                end
                3: begin
                    keep   = '1;
                    margin = SCORE_W'($urandom_range(0, 8));
                    tol    = '0;
                end
                default: begin
                    keep = ($urandom_range(0, 5) == 0) ? KEEP_W'($urandom_range(0, 15))
                                                       : KEEP_W'($urandom_range(1, 8));
                    case ($urandom_range(0, 4))
                        0:       margin = '0;
                        1:       margin = SCORE_TOP;
                        2:       margin = SCORE_W'($urandom_range(0, 8));
                        3:       margin = SCORE_W'($urandom_range(0, 600));
                        default: margin = SCORE_W'($urandom_range(0, SCORE_LIMIT));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       tol = '0;
                        1:       tol = UTIL_FULL;
                        2:       tol = UTIL_W'($urandom_range(0, 64));
                        default: tol = UTIL_W'($urandom_range(0, UTIL_LIMIT));
                    endcase
                end
            endcase
            program_regs(keep, margin, tol, 1'b0);

            phase_end = candidates_sent + $urandom_range(20, 40);
            // the last phase stops at the planned total
            if (phase_end > directed_count + RANDOM_ITEMS)
                phase_end = directed_count + RANDOM_ITEMS;
            while (candidates_sent < phase_end) begin
                level_len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20)
                                                        : $urandom_range(1, 9);
                spread    = t_spread'($urandom_range(0, 3));
                base      = SCORE_W'($urandom_range(0, SCORE_LIMIT - 1024));
                util_base = UTIL_W'($urandom_range(0, UTIL_LIMIT - 64));
                for (j = 0; j < level_len; j++) begin
                    case (spread)
                        SPREAD_TIGHT: score = base + SCORE_W'($urandom_range(0, 7));
                        SPREAD_NEAR:  score = base + SCORE_W'($urandom_range(0, 1023));
                        SPREAD_WIDE:  score = SCORE_W'($urandom_range(0, SCORE_LIMIT));
                        default: begin
                            case ($urandom_range(0, 3))
                                0:       score = '0;
                                1:       score = SCORE_W'(1);
                                2:       score = SCORE_TOP - 1'b1;
                                default: score = SCORE_TOP;
                            endcase
                        end
                    endcase
                    case ($urandom_range(0, 3))
                        0:       util = $urandom_range(0, 1) ? UTIL_FULL : '0;
                        1:       util = UTIL_W'($urandom_range(0, UTIL_LIMIT));
                        default: util = util_base + UTIL_W'($urandom_range(0, 63));
                    endcase
                    // close the level at its end, or now and then too early
                    send_candidate(score, util, ID_W'($urandom), ID_W'($urandom),
                                   (j == level_len - 1) || ($urandom_range(0, 24) == 0));
                    if (candidates_sent >= phase_end)
                        break;
                end
            end
            phase++;
        end

        settle();
        $display("covered %0d candidates (%0d directed) in %0d closed levels, %0d settings",
                 candidates_sent, directed_count, levels_closed, settings_used);
        $display("%0d results checked, %0d mismatches, %0d still predicted",
                 results_seen, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_beam_best_k_keeper_top passed");
        else
            $display("tb_beam_best_k_keeper_top failed");
        $finish;
    end

endmodule
